[rtl/nms_pkg.sv]
package nms_pkg;

  localparam int PHASE_W   = 15;
  localparam int COL_OUT_W = 10;
  localparam int ROW_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 12;

  typedef logic signed [PHASE_W-1:0] phase_t;
  typedef logic [ROW_W-1:0]          row_t;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BORDER = 2'd2;

  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;
  localparam logic [3:0]  BORDER_RST = 4'd2;

  // phase sector bounds in Q3.12, pi taken as 3.1416
  localparam phase_t SECT_A = -15'sd1608;
  localparam phase_t SECT_B = 15'sd1608;
  localparam phase_t SECT_C = 15'sd4825;
  localparam phase_t SECT_D = 15'sd8042;
  localparam phase_t SECT_E = 15'sd11259;

endpackage

[rtl/nms_line_ram.sv]
module nms_line_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 47,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/edge_non_maximum_suppression.sv]
// channel | dir | handshake              | payload
// in_     | in  | in_tvalid / in_tready  | tdata: magnitude, phase; tuser: frame_start
// out_    | out | out_tvalid / out_tready| tdata: suppressed, column, row
// cfg_    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
// one pixel per cycle while the output is not stalled; out_tvalid comes from the output register,
// loaded as the releasing pixel leaves the window stage; the line store read is registered beside
// the window stage, and a bypass covers back-to-back pixels that land on the same column
// rst_n is synchronous; counters, window and config return to their reset values,
// line store contents stay undefined until written
// a stalled output holds the window stage, which then holds off in_tready
module edge_non_maximum_suppression #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAG_WIDTH = 16,
  localparam int IN_DW    = ((MAG_WIDTH + nms_pkg::PHASE_W + 7) / 8) * 8,
  localparam int OUT_DW   = ((MAG_WIDTH + nms_pkg::COL_OUT_W + nms_pkg::ROW_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_DW-1:0]               in_tdata,   // magnitude, phase
  input  logic [0:0]                     in_tuser,   // frame_start
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_DW-1:0]              out_tdata,  // suppressed, column, row
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nms_pkg::CFG_DW-1:0]     cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int PW    = nms_pkg::PHASE_W;
  localparam int RW    = nms_pkg::ROW_W;
  localparam int RAM_W = 2 * MAG_WIDTH + PW;

  // configuration
  logic [10:0] cfg_width_r;
  logic [11:0] cfg_height_r;
  logic [3:0]  cfg_border_r;
  logic [WW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [3:0]    b_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= nms_pkg::WIDTH_RST;
      cfg_height_r <= nms_pkg::HEIGHT_RST;
      cfg_border_r <= nms_pkg::BORDER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nms_pkg::CFG_IDX_WIDTH:  cfg_width_r  <= cfg_data[10:0];
        nms_pkg::CFG_IDX_HEIGHT: cfg_height_r <= cfg_data[11:0];
        nms_pkg::CFG_IDX_BORDER: cfg_border_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_width_r < 11'd3) begin
      w_eff = WW'(3);
    end else if (32'(cfg_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_r);
    end
    h_eff = (cfg_height_r < 12'd3) ? 12'd3 : cfg_height_r;
    b_eff = (cfg_border_r == 4'd0) ? 4'd1 : cfg_border_r;
  end

  // input side and position counters
  logic in_xfer;
  logic [MAG_WIDTH-1:0] in_mag;
  nms_pkg::phase_t      in_ph;
  logic [CW-1:0] col_cnt_r, col_cnt_nxt, col_cur;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt, row_cur;
  logic [WW-1:0] col_inc;
  logic [RW:0]   row_inc;

  assign in_mag  = in_tdata[MAG_WIDTH-1:0];
  assign in_ph   = $signed(in_tdata[MAG_WIDTH+PW-1:MAG_WIDTH]);
  assign in_xfer = in_tvalid && in_tready;

  always_comb begin
    if (in_tuser[0] || (col_cnt_r >= w_eff)) begin
      col_cur = '0;
    end else begin
      col_cur = col_cnt_r;
    end
    if (in_tuser[0] || (row_cnt_r >= h_eff)) begin
      row_cur = '0;
    end else begin
      row_cur = row_cnt_r;
    end
    col_inc = WW'(col_cur) + WW'(1);
    row_inc = {1'b0, row_cur} + 13'd1;
    if (col_inc >= w_eff) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[RW-1:0];
    end else begin
      col_cnt_nxt = CW'(col_inc);
      row_cnt_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_xfer) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // window stage
  logic a_valid_r, a_adv, a_emit;
  logic [MAG_WIDTH-1:0] a_mag_r;
  nms_pkg::phase_t      a_ph_r;
  logic [CW-1:0]        a_col_r;
  logic [RW-1:0]        a_row_r;
  logic                 fwd_r;
  logic [RAM_W-1:0]     fwd_word_r;
  logic [RAM_W-1:0]     ram_rdata, line_word, ram_wdata;
  logic [MAG_WIDTH-1:0] up_eff, mid_eff;
  nms_pkg::phase_t      ph_eff;
  logic                 out_free;

  assign line_word = fwd_r ? fwd_word_r : ram_rdata;
  assign up_eff    = line_word[2*MAG_WIDTH+PW-1:MAG_WIDTH+PW];
  assign mid_eff   = line_word[MAG_WIDTH+PW-1:PW];
  assign ph_eff    = $signed(line_word[PW-1:0]);
  assign ram_wdata = {mid_eff, a_mag_r, a_ph_r};

  assign a_emit    = (a_row_r >= 12'd2) || ((a_row_r == 12'd1) && (a_col_r != '0));
  assign out_free  = !out_tvalid || out_tready;
  assign a_adv     = a_valid_r && (!a_emit || out_free);
  assign in_tready = !a_valid_r || a_adv;

  nms_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (RAM_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (a_adv),
    .waddr (a_col_r),
    .wdata (ram_wdata),
    .re    (in_xfer),
    .raddr (col_cur),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else if (in_xfer) begin
      a_valid_r <= 1'b1;
      // same column written by the leaving pixel: take its word directly
      fwd_r     <= a_adv && (a_col_r == col_cur);
    end else if (a_adv) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_mag_r    <= in_mag;
      a_ph_r     <= in_ph;
      a_col_r    <= col_cur;
      a_row_r    <= row_cur;
      fwd_word_r <= ram_wdata;
    end
  end

  // window registers: left column 0..2, centre column 3..5, upper to lower
  logic [MAG_WIDTH-1:0] win_r [6];
  nms_pkg::phase_t      ph_dly_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
      ph_dly_r <= '0;
    end else if (a_adv) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= up_eff;
      win_r[4] <= mid_eff;
      win_r[5] <= a_mag_r;
      ph_dly_r <= ph_eff;
    end
  end

  // suppression decision
  logic [WW-1:0]        ocol;
  logic [RW-1:0]        orow;
  logic                 in_bounds, sect_ok, bigger;
  logic [MAG_WIDTH-1:0] ctr, res;
  logic [OUT_DW-1:0]    out_word;

  always_comb begin
    ctr = win_r[4];
    if (a_col_r != '0) begin
      ocol = WW'(a_col_r) - WW'(1);
      orow = (a_row_r != '0) ? a_row_r - 12'd1 : a_row_r;
    end else begin
      ocol = w_eff - WW'(1);
      orow = (a_row_r >= 12'd2) ? a_row_r - 12'd2 : '0;
    end
    in_bounds = (a_col_r != '0)
             && (ocol >= WW'(b_eff)) && (({1'b0, ocol} + (WW+1)'(b_eff)) < {1'b0, w_eff})
             && (orow >= RW'(b_eff)) && (({1'b0, orow} + 13'(b_eff)) < {1'b0, h_eff});
    sect_ok = 1'b1;
    bigger  = 1'b0;
    priority if ((ph_dly_r >= nms_pkg::SECT_A) && (ph_dly_r < nms_pkg::SECT_B)) begin
      bigger = (win_r[1] > ctr) || (mid_eff > ctr);
    end else if ((ph_dly_r >= nms_pkg::SECT_B) && (ph_dly_r < nms_pkg::SECT_C)) begin
      bigger = (win_r[0] > ctr) || (a_mag_r > ctr);
    end else if ((ph_dly_r >= nms_pkg::SECT_C) && (ph_dly_r < nms_pkg::SECT_D)) begin
      bigger = (win_r[3] > ctr) || (win_r[5] > ctr);
    end else if ((ph_dly_r >= nms_pkg::SECT_D) && (ph_dly_r < nms_pkg::SECT_E)) begin
      bigger = (up_eff > ctr) || (win_r[2] > ctr);
    end else begin
      sect_ok = 1'b0;
    end
    res = (in_bounds && sect_ok && !bigger) ? ctr : '0;
    out_word = '0;
    out_word[MAG_WIDTH-1:0] = res;
    out_word[MAG_WIDTH+nms_pkg::COL_OUT_W-1:MAG_WIDTH] = nms_pkg::COL_OUT_W'(ocol);
    out_word[MAG_WIDTH+nms_pkg::COL_OUT_W+RW-1:MAG_WIDTH+nms_pkg::COL_OUT_W] = orow;
  end

  // output register
  logic              out_valid_r;
  logic [OUT_DW-1:0] out_data_r;
  logic              out_load;

  assign out_load   = a_adv && a_emit;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_word;
    end
  end

`ifndef SYNTHESIS
  a_accept_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && a_valid_r) |-> a_adv)
    else $error("pixel accepted while window stage is held");

  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(a_valid_r))
    else $error("result appeared without a pixel in the window stage");

  a_same_col_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && a_adv && (a_col_r == col_cur)) |=> fwd_r)
    else $error("same-column line store hazard not bypassed");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result register overwritten before transfer");
`endif

endmodule

[tb/sv/nms_checker.sv]
module nms_checker #(
  parameter int MAX_WIDTH = 1024,
  parameter int IN_DW     = 32,
  parameter int OUT_DW    = 40
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [IN_DW-1:0]              in_tdata,   // magnitude, phase
  input  logic [0:0]                    in_tuser,   // frame_start
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [OUT_DW-1:0]             out_tdata,  // suppressed, column, row
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [nms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nms_pkg::CFG_DW-1:0]    cfg_data,
  output int                            pending,
  output int                            error_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAG_W      = 16;
  localparam int MIN_DIM    = 3;
  localparam int MAX_HEIGHT = 4095;
  localparam int COL_W      = nms_pkg::COL_OUT_W;

  typedef struct packed {
    logic [MAG_W-1:0] suppressed;
    logic [COL_W-1:0] column;
    nms_pkg::row_t    row;
  } pixel_result_t;

  logic [MAG_W-1:0] upper_line  [MAX_WIDTH];
  logic [MAG_W-1:0] middle_line [MAX_WIDTH];
  nms_pkg::phase_t  phase_line  [MAX_WIDTH];
  logic [MAG_W-1:0] win [6];
  int unsigned      col_cnt;
  int unsigned      row_cnt;
  nms_pkg::phase_t  phase_hold;
  logic [10:0]      width_reg;
  logic [11:0]      height_reg;
  logic [3:0]       border_reg;
  pixel_result_t    pixel_results_q [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic clear_state();
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
      phase_line[i]  = '0;
    end
    for (int i = 0; i < 6; i++) win[i] = '0;
    col_cnt     = 0;
    row_cnt     = 0;
    phase_hold  = '0;
    width_reg   = nms_pkg::WIDTH_RST;
    height_reg  = nms_pkg::HEIGHT_RST;
    border_reg  = nms_pkg::BORDER_RST;
    error_count = 0;
    pixel_results_q.delete();
  endtask

  // works out the result that this pixel transfer releases, if any
  task automatic predict_suppression(input logic [MAG_W-1:0] mag, input nms_pkg::phase_t ph,
                                     input logic fs);
    int unsigned w, h, b, x, y, ox, oy;
    logic [MAG_W-1:0] up, mid, ul, ml, ll, uc, c, lc, ur, mr, lr;
    nms_pkg::phase_t pc;
    logic emit, bigger, in_sector;
    pixel_result_t r;
    w = width_reg;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = height_reg;
    if (h < MIN_DIM) h = MIN_DIM;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    b = border_reg;
    if (b < 1) b = 1;

    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= w) col_cnt = 0;
    if (row_cnt >= h) row_cnt = 0;
    x = col_cnt;
    y = row_cnt;

    up  = upper_line[x];
    mid = middle_line[x];
    upper_line[x]  = mid;
    middle_line[x] = mag;
    pc = phase_hold;
    phase_hold    = phase_line[x];
    phase_line[x] = ph;

    emit = (y >= 2) || (y == 1 && x >= 1);
    // column zero releases the last pixel of the row two above
    if (x >= 1) begin
      ox = x - 1;
      oy = (y >= 1) ? y - 1 : 0;
    end else begin
      ox = w - 1;
      oy = (y >= 2) ? y - 2 : 0;
    end

    r.suppressed = '0;
    if (emit && x >= 1 && ox >= b && ox + b < w && oy >= b && oy + b < h) begin
      ul = win[0];
      ml = win[1];
      ll = win[2];
      uc = win[3];
      c  = win[4];
      lc = win[5];
      ur = up;
      mr = mid;
      lr = mag;
      in_sector = 1'b1;
      bigger    = 1'b0;
      if (pc >= nms_pkg::SECT_A && pc < nms_pkg::SECT_B)
        bigger = (ml > c) || (mr > c);
      else if (pc >= nms_pkg::SECT_B && pc < nms_pkg::SECT_C)
        bigger = (ul > c) || (lr > c);
      else if (pc >= nms_pkg::SECT_C && pc < nms_pkg::SECT_D)
        bigger = (uc > c) || (lc > c);
      else if (pc >= nms_pkg::SECT_D && pc < nms_pkg::SECT_E)
        bigger = (ur > c) || (ll > c);
      else in_sector = 1'b0;
      if (in_sector && !bigger) r.suppressed = c;
    end

    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = up;
    win[4] = mid;
    win[5] = mag;

    if (x + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_cnt = x + 1;
    end

    if (emit) begin
      r.column = ox[COL_W-1:0];
      r.row    = oy[nms_pkg::ROW_W-1:0];
      pixel_results_q.insert(pixel_results_q.size(), r);
    end
  endtask

  task automatic check_result(input logic [OUT_DW-1:0] data);
    pixel_result_t want;
    if (pixel_results_q.size() == 0) begin
      report_mismatch("unexpected result", data[31:0], '0);
      return;
    end
    want = pixel_results_q.pop_front();
    if (data[MAG_W-1:0] !== want.suppressed)
      report_mismatch("suppressed", 32'(data[MAG_W-1:0]), 32'(want.suppressed));
    if (data[MAG_W +: COL_W] !== want.column)
      report_mismatch("column", 32'(data[MAG_W +: COL_W]), 32'(want.column));
    if (data[MAG_W+COL_W +: nms_pkg::ROW_W] !== want.row)
      report_mismatch("row", 32'(data[MAG_W+COL_W +: nms_pkg::ROW_W]), 32'(want.row));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          nms_pkg::CFG_IDX_WIDTH:  width_reg  = cfg_data[10:0];
          nms_pkg::CFG_IDX_HEIGHT: height_reg = cfg_data[11:0];
          nms_pkg::CFG_IDX_BORDER: border_reg = cfg_data[3:0];
          default: ;
        endcase
      end
      // results leave before this edge's pixel is taken in
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (in_tvalid && in_tready)
        predict_suppression(in_tdata[MAG_W-1:0],
                            nms_pkg::phase_t'(in_tdata[MAG_W +: nms_pkg::PHASE_W]),
                            in_tuser[0]);
    end
    pending <= pixel_results_q.size();
  end

endmodule

[tb/sv/tb_edge_non_maximum_suppression.sv]
module tb_edge_non_maximum_suppression ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_DW        = 32;
  localparam int OUT_DW       = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_ENDS  = 16;
  localparam int MAX_GAP      = 14;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [IN_DW-1:0]              in_tdata;   // magnitude, phase
  logic [0:0]                    in_tuser;   // frame_start
  logic                          out_tvalid;
  logic                          out_tready;
  logic [OUT_DW-1:0]             out_tdata;  // suppressed, column, row
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [nms_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [nms_pkg::CFG_DW-1:0]    cfg_data;

  int pending_results;
  int error_count;
  int cycle_count = 0;
  bit in_burst    = 1'b0;
  bit out_burst   = 1'b0;

  always #2 clk = ~clk;

  edge_non_maximum_suppression u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  nms_checker #(
    .IN_DW  (IN_DW),
    .OUT_DW (OUT_DW)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pending     (pending_results),
    .error_count (error_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic nms_pkg::phase_t sector_edge(input int k);
    case (k % 14)
      0:       return -15'sd12868;
      1:       return nms_pkg::SECT_A - 15'sd1;
      2:       return nms_pkg::SECT_A;
      3:       return -15'sd1;
      4:       return '0;
      5:       return nms_pkg::SECT_B - 15'sd1;
      6:       return nms_pkg::SECT_B;
      7:       return nms_pkg::SECT_C - 15'sd1;
      8:       return nms_pkg::SECT_C;
      9:       return nms_pkg::SECT_D - 15'sd1;
      10:      return nms_pkg::SECT_D;
      11:      return nms_pkg::SECT_E - 15'sd1;
      12:      return nms_pkg::SECT_E;
      default: return 15'sd12868;
    endcase
  endfunction

  function automatic nms_pkg::phase_t pick_phase();
    int v;
    if ($urandom_range(0, 3) == 0) return sector_edge($urandom_range(0, 13));
    v = int'($urandom_range(0, 25736)) - 12868;
    return nms_pkg::phase_t'(v);
  endfunction

  // small values give plenty of ties, which must not suppress
  function automatic logic [15:0] pick_magnitude();
    case ($urandom_range(0, 5))
      0:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      1, 2:    return 16'($urandom_range(0, 3));
      3:       return 16'h8000 + 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // in_tvalid may stay high from the previous transfer
  task automatic drive_pixel(input logic [15:0] mag, input nms_pkg::phase_t ph,
                             input logic fs);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, ph, mag};
    in_tuser  <= fs;
    do @(posedge clk); while (!in_tready);
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
  endtask

  // hold the sender until every result is out, then let the pipeline empty
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_ENDS) @(posedge clk);
  endtask

  task automatic configure(input logic [nms_pkg::CFG_DW-1:0] w,
                           input logic [nms_pkg::CFG_DW-1:0] h,
                           input logic [nms_pkg::CFG_DW-1:0] b);
    logic [nms_pkg::CFG_IDX_W-1:0] idx [3];
    logic [nms_pkg::CFG_DW-1:0]    vals [3];
    idx  = '{nms_pkg::CFG_IDX_WIDTH, nms_pkg::CFG_IDX_HEIGHT, nms_pkg::CFG_IDX_BORDER};
    vals = '{w, h, b};
    cfg_valid <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      cfg_index <= idx[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // a run of pixels with random content, plus the odd stray frame start
  task automatic run_frames(input int n_items, input bit restart);
    logic fs;
    for (int k = 0; k < n_items; k++) begin
      fs = (k == 0 && restart) || ($urandom_range(0, 99) == 0);
      drive_pixel(pick_magnitude(), pick_phase(), fs);
      if ($urandom_range(0, 299) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    int gap;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = out_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
    end
  end

  initial begin
    logic [15:0] mag;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= nms_pkg::CFG_IDX_WIDTH;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // counters start at the origin after reset: the first row releases nothing
    for (int i = 0; i < 12; i++) drive_pixel(pick_magnitude(), pick_phase(), 1'b0);
    drain_results();

    // one 5x5 frame sweeping sector bounds and magnitude extremes
    configure(12'd5, 12'd5, 12'd1);
    for (int i = 0; i < 25; i++) begin
      case (i % 4)
        0:       mag = 16'hFFFF;
        1:       mag = 16'h0000;
        2:       mag = 16'h7FFF;
        default: mag = 16'h0100;
      endcase
      drive_pixel(mag, sector_edge(i), i == 0);
    end
    drain_results();

    // zero registers clamp to the smallest frame
    configure(12'd0, 12'd0, 12'd0);
    run_frames(60, 1'b1);
    configure(12'd8, 12'd6, 12'd1);
    run_frames(120, 1'b1);
    configure(12'd16, 12'd4095, 12'd3);
    run_frames(120, 1'b1);
    // shrink without a frame start: stale counters wrap into the new frame
    configure(12'd8, 12'd5, 12'd2);
    run_frames(100, 1'b0);
    configure(12'd12, 12'd9, 12'd15);
    run_frames(80, 1'b1);
    configure(12'd10, 12'd8, 12'd1);
    run_frames(120, 1'b1);
    // oversized width clamps to the store depth
    configure(12'hFFF, 12'd3, 12'd1);
    run_frames(120, 1'b1);
    configure(12'd5, 12'd4, 12'd1);
    run_frames(100, 1'b1);

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
